FILE: rtl/fdhp_pkg.sv
package fdhp_pkg;

    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_STEPS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HP_B0         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HP_A1         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HP_A2         = 3'd6;

    localparam logic [6:0]  STEPS_MIN = 7'd2;
    localparam logic [6:0]  STEPS_MAX = 7'd100;

    // divider walks the 17-bit dividend 65536 one bit a cycle
    localparam logic [16:0] DIV_NUMER  = 17'h10000;
    localparam logic [4:0]  DIV_LAST   = 5'd16;

    typedef struct packed {
        logic clr;
        logic load;
        logic div;
        logic rd;
        logic mul;
        logic wr;
        logic fx;
        logic fy;
        logic fa1;
        logic fm1;
        logic fm2;
        logic out;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic step_last;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/fdhp_ram.sv
module fdhp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/fdhp_ctrl.sv
module fdhp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fdhp_pkg::status_t st,
    output fdhp_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_RD    = 4'd3;
    localparam logic [3:0] ST_MUL   = 4'd4;
    localparam logic [3:0] ST_WR    = 4'd5;
    localparam logic [3:0] ST_FRD   = 4'd6;
    localparam logic [3:0] ST_FX    = 4'd7;
    localparam logic [3:0] ST_FY    = 4'd8;
    localparam logic [3:0] ST_FA1   = 4'd9;
    localparam logic [3:0] ST_FM1   = 4'd10;
    localparam logic [3:0] ST_FM2   = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (st.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div = 1'b1;
                if (st.div_last)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                cmd.wr     = 1'b1;
                state_next = st.step_last ? ST_FRD : ST_RD;
            end
            ST_FRD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_FX;
            end
            ST_FX:
            begin
                cmd.fx     = 1'b1;
                state_next = ST_FY;
            end
            ST_FY:
            begin
                cmd.fy     = 1'b1;
                state_next = ST_FA1;
            end
            ST_FA1:
            begin
                cmd.fa1    = 1'b1;
                state_next = ST_FM1;
            end
            ST_FM1:
            begin
                cmd.fm1    = 1'b1;
                state_next = ST_FM2;
            end
            ST_FM2:
            begin
                cmd.fm2    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr, cmd.load, cmd.div, cmd.rd, cmd.mul, cmd.wr,
                  cmd.fx, cmd.fy, cmd.fa1, cmd.fm1, cmd.fm2, cmd.out}))
        else $error("more than one datapath command");
    a_load_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.div)
        else $error("divide did not follow load");
    a_last_filter: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr && st.step_last) |=> cmd.rd)
        else $error("filter read did not follow last write");
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out |-> st.out_free)
        else $error("result overwritten");
`endif

endmodule

FILE: rtl/fdhp_dp.sv
module fdhp_dp #(
    parameter int LINE_DEPTH   = 524288,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fdhp_pkg::cmd_t                cmd,
    output fdhp_pkg::status_t             st,
    input  logic [6:0]                    steps,
    input  logic [14:0]                   fb_gain,
    input  logic [15:0]                   level,
    input  logic [$clog2(LINE_DEPTH):0]   len,
    input  logic signed [23:0]            b0,
    input  logic signed [23:0]            a1,
    input  logic signed [23:0]            a2,
    input  logic signed [15:0]            sample_in,
    output logic signed [15:0]            sample_out,
    output logic                          out_valid,
    input  logic                          out_ready
);

    localparam int PW  = $clog2(LINE_DEPTH);
    localparam int SW  = SAMPLE_WIDTH;
    localparam int EW  = ((SW + 2 > 16) ? SW + 2 : 16) + 1;
    localparam int P0W = 24 + SW;
    localparam logic signed [EW-1:0] E_HI = {{(EW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [EW-1:0] E_LO = {{(EW-SW+1){1'b1}}, {(SW-1){1'b0}}};
    localparam logic signed [36:0]   O_HI = {{(38-SW){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [36:0]   O_LO = {{(38-SW){1'b1}}, {(SW-1){1'b0}}};
    localparam logic [PW-1:0]        CLR_END = PW'(LINE_DEPTH - 1);

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = 40'sh007FFFFFFF;
        lo = -hi - 40'sd1;
        if (v > hi)
            return 32'sh7FFFFFFF;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    logic [PW-1:0]          clr_addr_reg;
    logic [PW-1:0]          pos_reg;
    logic signed [15:0]     cur_reg;
    logic signed [15:0]     prev_reg;
    logic [6:0]             div_rem_reg;
    logic [16:0]            div_q_reg;
    logic [4:0]             div_cnt_reg;
    logic [16:0]            w_reg;
    logic [6:0]             r_reg;
    logic [6:0]             step_cnt_reg;
    logic signed [34:0]     ip_reg;
    logic signed [15:0]     s_reg;
    logic signed [SW+15:0]  ef_reg;
    logic signed [P0W-1:0]  p0_reg;
    logic signed [31:0]     y_reg;
    logic signed [55:0]     pa_reg;
    logic signed [31:0]     m1_reg;
    logic signed [31:0]     m2_reg;
    logic signed [48:0]     po_reg;
    logic signed [15:0]     out_reg;
    logic                   out_valid_reg;

    logic                   mem_we;
    logic [PW-1:0]          mem_addr;
    logic [SW-1:0]          mem_wdata;
    logic signed [SW-1:0]   mem_rdata;
    logic [SW-1:0]          mem_rdata_raw;

    logic [6:0]             divisor;
    logic [7:0]             div_trial;
    logic                   div_ge;
    logic [7:0]             r_sum;
    logic                   r_wrap;
    logic [PW:0]            pos_inc;
    logic signed [16:0]     diff;
    logic signed [19:0]     s_wide;
    logic signed [EW-1:0]   e_sum;
    logic [SW-1:0]          e_new;
    logic signed [57:0]     m1_t;
    logic signed [56:0]     m2_t;
    logic signed [36:0]     o_sh;
    logic signed [36:0]     o_sat;

    assign divisor   = steps - 7'd1;
    assign div_trial = {div_rem_reg, div_q_reg[16]};
    assign div_ge    = (div_trial >= {1'b0, divisor});
    assign r_sum     = {1'b0, r_reg} + {1'b0, div_rem_reg};
    assign r_wrap    = (r_sum >= {1'b0, divisor});
    assign pos_inc   = {1'b0, pos_reg} + {{PW{1'b0}}, 1'b1};
    assign diff      = {cur_reg[15], cur_reg} - {prev_reg[15], prev_reg};
    assign s_wide    = {{4{prev_reg[15]}}, prev_reg} + {ip_reg[34], ip_reg[34:16]};
    assign e_sum     = EW'($signed(ef_reg[SW+15:14])) + EW'(s_reg);
    assign m1_t      = -(58'(p0_reg) <<< 1) - 58'(pa_reg);
    assign m2_t      = 57'(p0_reg) - 57'(pa_reg);
    assign o_sh      = po_reg[48:12];

    always_comb
    begin
        if (e_sum > E_HI)
            e_new = E_HI[SW-1:0];
        else if (e_sum < E_LO)
            e_new = E_LO[SW-1:0];
        else
            e_new = e_sum[SW-1:0];
        if (o_sh > O_HI)
            o_sat = O_HI;
        else if (o_sh < O_LO)
            o_sat = O_LO;
        else
            o_sat = o_sh;
    end

    assign mem_we    = cmd.clr | cmd.wr;
    assign mem_addr  = cmd.clr ? clr_addr_reg : pos_reg;
    assign mem_wdata = cmd.clr ? '0 : e_new;
    assign mem_rdata = $signed(mem_rdata_raw);

    fdhp_ram #(
        .WIDTH (SW),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata_raw)
    );

    assign st.clr_last  = (clr_addr_reg == CLR_END);
    assign st.div_last  = (div_cnt_reg == fdhp_pkg::DIV_LAST);
    assign st.step_last = (step_cnt_reg == divisor);
    assign st.out_free  = !out_valid_reg || out_ready;

    assign sample_out = out_reg;
    assign out_valid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            pos_reg       <= '0;
            prev_reg      <= '0;
            m1_reg        <= '0;
            m2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                clr_addr_reg <= clr_addr_reg + {{(PW-1){1'b0}}, 1'b1};
            end
            if (cmd.wr)
            begin
                pos_reg <= (pos_inc >= len) ? '0 : pos_inc[PW-1:0];
            end
            if (cmd.fm1)
            begin
                m1_reg <= sat32(40'($signed(m1_t[57:20])) + 40'(m2_reg));
            end
            if (cmd.fm2)
            begin
                m2_reg   <= sat32(40'($signed(m2_t[56:20])));
                prev_reg <= cur_reg;
            end
            if (cmd.out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg      <= sample_in;
            div_rem_reg  <= '0;
            div_q_reg    <= fdhp_pkg::DIV_NUMER;
            div_cnt_reg  <= '0;
            w_reg        <= '0;
            r_reg        <= '0;
            step_cnt_reg <= '0;
        end
        if (cmd.div)
        begin
            div_rem_reg <= div_ge ? 7'(div_trial - {1'b0, divisor}) : div_trial[6:0];
            div_q_reg   <= {div_q_reg[15:0], div_ge};
            div_cnt_reg <= div_cnt_reg + 5'd1;
        end
        if (cmd.rd)
        begin
            ip_reg <= diff * $signed({1'b0, w_reg});
        end
        if (cmd.mul)
        begin
            s_reg  <= s_wide[15:0];
            ef_reg <= mem_rdata * $signed({1'b0, fb_gain});
        end
        if (cmd.wr)
        begin
            step_cnt_reg <= step_cnt_reg + 7'd1;
            w_reg        <= w_reg + div_q_reg + {16'd0, r_wrap};
            r_reg        <= r_wrap ? 7'(r_sum - {1'b0, divisor}) : r_sum[6:0];
        end
        if (cmd.fx)
        begin
            p0_reg <= b0 * mem_rdata;
        end
        if (cmd.fy)
        begin
            y_reg <= sat32(40'($signed(p0_reg[P0W-1:20])) + 40'(m1_reg));
        end
        if (cmd.fa1)
        begin
            pa_reg <= a1 * y_reg;
        end
        if (cmd.fm1)
        begin
            pa_reg <= a2 * y_reg;
        end
        if (cmd.fm2)
        begin
            po_reg <= y_reg * $signed({1'b0, level});
        end
        if (cmd.out)
        begin
            out_reg <= o_sat[15:0];
        end
    end

endmodule

FILE: rtl/feedback_delay_highpass_core.sv
// Feedback delay line with a highpass biquad. Each input item is one Q1.15
// sample; each gives one Q1.15 result item. After reset the delay memory is
// cleared one entry a cycle with in_ready low (configuration writes are
// still taken). An item then runs through bit-serial division for the
// interpolation step, a read-scale-write of the single-port delay memory
// for each write step, and then the filter and output scaling steps. The
// next item is taken while the previous result waits in the output
// register.
module feedback_delay_highpass_core #(
    parameter int LINE_DEPTH   = 524288,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [15:0]                  sample_in,
    input  logic                                in_valid,
    output logic                                in_ready,
    output logic signed [15:0]                  sample_out,
    output logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                cfg_we,
    input  logic [fdhp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fdhp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LENW = $clog2(LINE_DEPTH) + 1;

    logic [6:0]         speed_steps_reg;
    logic [14:0]        feedback_gain_reg;
    logic [15:0]        output_level_reg;
    logic [19:0]        delay_length_reg;
    logic signed [23:0] hp_b0_reg;
    logic signed [23:0] hp_a1_reg;
    logic signed [23:0] hp_a2_reg;

    logic [6:0]         steps;
    logic [LENW-1:0]    len;

    fdhp_pkg::cmd_t     cmd;
    fdhp_pkg::status_t  st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_steps_reg   <= 7'd2;
            feedback_gain_reg <= '0;
            output_level_reg  <= '0;
            delay_length_reg  <= 20'd441000;
            hp_b0_reg         <= 24'sd4194304;
            hp_a1_reg         <= '0;
            hp_a2_reg         <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fdhp_pkg::REG_SPEED_STEPS:   speed_steps_reg   <= cfg_data[6:0];
                fdhp_pkg::REG_FEEDBACK_GAIN: feedback_gain_reg <= cfg_data[14:0];
                fdhp_pkg::REG_OUTPUT_LEVEL:  output_level_reg  <= cfg_data[15:0];
                fdhp_pkg::REG_DELAY_LENGTH:  delay_length_reg  <= cfg_data[19:0];
                fdhp_pkg::REG_HP_B0:         hp_b0_reg         <= $signed(cfg_data);
                fdhp_pkg::REG_HP_A1:         hp_a1_reg         <= $signed(cfg_data);
                fdhp_pkg::REG_HP_A2:         hp_a2_reg         <= $signed(cfg_data);
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        if (speed_steps_reg < fdhp_pkg::STEPS_MIN)
            steps = fdhp_pkg::STEPS_MIN;
        else if (speed_steps_reg > fdhp_pkg::STEPS_MAX)
            steps = fdhp_pkg::STEPS_MAX;
        else
            steps = speed_steps_reg;
        if (delay_length_reg == '0)
            len = LENW'(1);
        else if ({1'b0, delay_length_reg} > 21'(LINE_DEPTH))
            len = LENW'(LINE_DEPTH);
        else
            len = LENW'(delay_length_reg);
    end

    fdhp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    fdhp_dp #(
        .LINE_DEPTH   (LINE_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .steps      (steps),
        .fb_gain    (feedback_gain_reg),
        .level      (output_level_reg),
        .len        (len),
        .b0         (hp_b0_reg),
        .a1         (hp_a1_reg),
        .a2         (hp_a2_reg),
        .sample_in  (sample_in),
        .sample_out (sample_out),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

FILE: bench/feedback_delay_highpass_core_test.sv
module feedback_delay_highpass_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 524288;
    localparam int IDLE_LIMIT = 1500000;

    localparam logic [fdhp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic signed [15:0]                  sample_in = '0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic signed [15:0]                  sample_out;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [fdhp_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [fdhp_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    feedback_delay_highpass_core DUT (
        .clk(clk), .rst_n(rst_n),
        .sample_in(sample_in), .in_valid(in_valid), .in_ready(in_ready),
        .sample_out(sample_out), .out_valid(out_valid), .out_ready(out_ready),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // delay line and filter state
    logic signed [15:0] line_mem [int];
    int unsigned        line_pos;
    longint             last_sample;
    longint             hist_one;
    longint             hist_two;
    int unsigned        steps_reg;
    int unsigned        fb_reg;
    int unsigned        level_reg;
    int unsigned        length_reg;
    longint             b0_reg;
    longint             a1_reg;
    longint             a2_reg;

    logic signed [15:0] pending_out [$];
    int                 errors = 0;
    int                 items_sent = 0;
    int                 items_seen = 0;
    int                 idle_cycles = 0;
    int                 hold_off = 0;
    int                 stall_mode = 0;

    function automatic longint clamp_sample(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint line_read(int unsigned p);
        if (line_mem.exists(p)) return line_mem[p];
        return 0;
    endfunction

    function automatic logic signed [15:0] delay_filter(logic signed [15:0] din);
        longint      cur;
        longint      w;
        longint      s;
        longint      e;
        longint      x;
        longint      y;
        longint      m1;
        longint      m2;
        int unsigned n;
        int unsigned len;
        int unsigned p;
        cur = din;
        n = steps_reg;
        len = length_reg;
        if (n < 2) n = 2;
        if (n > 100) n = 100;
        if (len == 0) len = 1;
        if (len > DEPTH) len = DEPTH;
        for (int unsigned i = 0; i < n; i++)
        begin
            w = (longint'(i) << 16) / longint'(n - 1);
            s = (last_sample * (65536 - w) + cur * w) >>> 16;
            p = line_pos % DEPTH;
            e = ((line_read(p) * longint'(fb_reg)) >>> 14) + s;
            line_mem[p] = 16'(clamp_sample(e));
            line_pos = (p + 1 >= len) ? 0 : p + 1;
        end
        last_sample = cur;
        x = line_read(line_pos % DEPTH);
        y = clamp32(((b0_reg * x) >>> 20) + hist_one);
        m1 = clamp32(((-2 * b0_reg * x - a1_reg * y) >>> 20) + hist_two);
        m2 = clamp32((b0_reg * x - a2_reg * y) >>> 20);
        hist_one = m1;
        hist_two = m2;
        return 16'(clamp_sample((y * longint'(level_reg)) >>> 12));
    endfunction

    function automatic void apply_reg(logic [fdhp_pkg::CFG_IDX_W-1:0] idx,
                                      logic [fdhp_pkg::CFG_DATA_W-1:0] d);
        case (idx)
            fdhp_pkg::REG_SPEED_STEPS:   steps_reg = d[6:0];
            fdhp_pkg::REG_FEEDBACK_GAIN: fb_reg = d[14:0];
            fdhp_pkg::REG_OUTPUT_LEVEL:  level_reg = d[15:0];
            fdhp_pkg::REG_DELAY_LENGTH:  length_reg = d[19:0];
            fdhp_pkg::REG_HP_B0:         b0_reg = longint'($signed(d));
            fdhp_pkg::REG_HP_A1:         a1_reg = longint'($signed(d));
            fdhp_pkg::REG_HP_A2:         a2_reg = longint'($signed(d));
            default:                     ;
        endcase
    endfunction

    task automatic wait_idle();
        wait (pending_out.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_reg(logic [fdhp_pkg::CFG_IDX_W-1:0] idx,
                           logic [fdhp_pkg::CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        apply_reg(idx, d);
    endtask

    task automatic send_item(logic signed [15:0] d);
        @(negedge clk);
        in_valid <= 1'b1;
        sample_in <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_out.push_back(delay_filter(d));
        items_sent++;
    endtask

    task automatic pause_sender(int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($signed($urandom_range(0, 511)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_defaults();
        send_item(16'sh7FFF);
        send_item(16'sh8000);
        send_item(16'sh0000);
        pause_sender(1);
    endtask

    task automatic test_sample_extremes();
        wait_idle();
        set_reg(fdhp_pkg::REG_OUTPUT_LEVEL, 24'd4096);
        set_reg(fdhp_pkg::REG_DELAY_LENGTH, 24'd5);
        set_reg(fdhp_pkg::REG_FEEDBACK_GAIN, 24'd16384);
        set_reg(fdhp_pkg::REG_SPEED_STEPS, 24'd4);
        send_item(16'sh7FFF);
        send_item(16'sh7FFF);
        send_item(16'sh8000);
        send_item(16'sh8000);
        send_item(16'sh0001);
        send_item(16'shFFFF);
        pause_sender(1);
    endtask

    task automatic test_register_corners();
        wait_idle();
        set_reg(fdhp_pkg::REG_SPEED_STEPS, 24'd0);
        set_reg(fdhp_pkg::REG_DELAY_LENGTH, 24'd0);
        set_reg(fdhp_pkg::REG_FEEDBACK_GAIN, 24'd32767);
        set_reg(fdhp_pkg::REG_OUTPUT_LEVEL, 24'd65535);
        set_reg(fdhp_pkg::REG_HP_B0, 24'h7FFFFF);
        set_reg(fdhp_pkg::REG_HP_A1, 24'h800000);
        set_reg(fdhp_pkg::REG_HP_A2, 24'h7FFFFF);
        set_reg(REG_UNMAPPED, 24'hFFFFFF);
        send_item(16'sh7FFF);
        send_item(16'sh8000);
        pause_sender(1);
        wait_idle();
        set_reg(fdhp_pkg::REG_SPEED_STEPS, 24'd1);
        set_reg(fdhp_pkg::REG_DELAY_LENGTH, 24'hFFFFF);
        set_reg(fdhp_pkg::REG_HP_B0, 24'h800000);
        set_reg(fdhp_pkg::REG_HP_A1, 24'd0);
        set_reg(fdhp_pkg::REG_HP_A2, 24'd0);
        send_item(16'sh4000);
        send_item(16'shC000);
        pause_sender(1);
        wait_idle();
        set_reg(fdhp_pkg::REG_SPEED_STEPS, 24'd127);
        set_reg(fdhp_pkg::REG_DELAY_LENGTH, 24'd524288);
        set_reg(fdhp_pkg::REG_HP_B0, 24'd1048576);
        set_reg(fdhp_pkg::REG_OUTPUT_LEVEL, 24'd0);
        send_item(16'sh1234);
        pause_sender(1);
        wait_idle();
        set_reg(fdhp_pkg::REG_SPEED_STEPS, 24'd100);
        set_reg(fdhp_pkg::REG_OUTPUT_LEVEL, 24'd4096);
        send_item(16'sh8000);
        pause_sender(1);
    endtask

    task automatic test_length_shrink();
        wait_idle();
        set_reg(fdhp_pkg::REG_SPEED_STEPS, 24'd20);
        set_reg(fdhp_pkg::REG_DELAY_LENGTH, 24'd50);
        set_reg(fdhp_pkg::REG_FEEDBACK_GAIN, 24'd8192);
        send_item(16'sh2000);
        send_item(16'shE000);
        pause_sender(1);
        wait_idle();
        set_reg(fdhp_pkg::REG_DELAY_LENGTH, 24'd3);
        send_item(16'sh7000);
        send_item(16'sh0100);
        pause_sender(1);
    endtask

    task automatic random_config();
        wait_idle();
        set_reg(fdhp_pkg::REG_SPEED_STEPS, ($urandom_range(0, 9) == 0) ?
                24'($urandom_range(0, 127)) : 24'($urandom_range(2, 12)));
        set_reg(fdhp_pkg::REG_FEEDBACK_GAIN, ($urandom_range(0, 3) == 0) ?
                24'($urandom_range(0, 32767)) : 24'($urandom_range(0, 16384)));
        set_reg(fdhp_pkg::REG_OUTPUT_LEVEL, ($urandom_range(0, 3) == 0) ?
                24'($urandom_range(0, 65535)) : 24'($urandom_range(1024, 8192)));
        set_reg(fdhp_pkg::REG_DELAY_LENGTH, ($urandom_range(0, 7) == 0) ?
                24'($urandom_range(0, 1048575)) : 24'($urandom_range(0, 64)));
        set_reg(fdhp_pkg::REG_HP_B0, 24'($urandom));
        if ($urandom_range(0, 1))
        begin
            set_reg(fdhp_pkg::REG_HP_A1, 24'($urandom));
            set_reg(fdhp_pkg::REG_HP_A2, 24'($urandom));
        end
        else
        begin
            set_reg(fdhp_pkg::REG_HP_A1,
                    24'($signed($urandom_range(0, 4194304)) - 2097152));
            set_reg(fdhp_pkg::REG_HP_A2, 24'($urandom_range(0, 1048576)));
        end
    endtask

    task automatic test_random_traffic();
        int burst;
        for (int ph = 0; ph < 10; ph++)
        begin
            random_config();
            stall_mode = ph % 3;
            for (int k = 0; k < 150; k += burst)
            begin
                burst = $urandom_range(1, 20);
                for (int j = 0; j < burst; j++)
                    send_item(rand_sample());
                if (ph % 4 != 3)
                    pause_sender($urandom_range(1, 8));
            end
            pause_sender(1);
        end
        stall_mode = 0;
    endtask

    task automatic test_backpressure();
        wait_idle();
        set_reg(fdhp_pkg::REG_SPEED_STEPS, 24'd3);
        set_reg(fdhp_pkg::REG_DELAY_LENGTH, 24'd17);
        hold_off = 3000;
        for (int j = 0; j < 30; j++)
            send_item(rand_sample());
        pause_sender(1);
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                default: out_ready <= ($urandom_range(0, 15) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            items_seen++;
            if (pending_out.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item, actual sample_out %0d", $realtime, sample_out);
            end
            else
            begin
                if (sample_out !== pending_out[0])
                begin
                    errors++;
                    $display("%0t: sample_out expected %0d actual %0d", $realtime,
                             pending_out[0], sample_out);
                end
                void'(pending_out.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d items outstanding", $realtime,
                     pending_out.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        line_pos = 0;
        last_sample = 0;
        hist_one = 0;
        hist_two = 0;
        steps_reg = 2;
        fb_reg = 0;
        level_reg = 0;
        length_reg = 441000;
        b0_reg = 4194304;
        a1_reg = 0;
        a2_reg = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_defaults();
        test_sample_extremes();
        test_register_corners();
        test_length_shrink();
        test_random_traffic();
        test_backpressure();

        wait (pending_out.size() == 0);
        repeat (400) @(posedge clk);
        $display("Sent %0d samples, checked %0d results over corner and random settings,",
                 items_sent, items_seen);
        $display("with bursty input, receiver stalls and one long output hold-off.");
        if (errors == 0 && pending_out.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
